### sv/assert_macros.svh
// assertion macros used by mipmap_box_downsampler
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/mipbox_pkg.sv
// constants, types and pixel helpers of the 2x2 mipmap downsampler
// no dependencies
package mipbox_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SLOT_W     = $clog2(LINE_DEPTH);
  localparam int EW_W       = $clog2(MAX_WIDTH + 1);
  localparam int EH_W       = $clog2(MAX_HEIGHT + 1);

  localparam int PIX_W      = 32;
  localparam int CFG_WID_W  = 12;
  localparam int CFG_HGT_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_ADDR_W = 2;

  localparam logic [PIX_W-1:0] BYTE_LSB_CLEAR = 32'hfefefefe;
  localparam logic [PIX_W-1:0] COLOR_MASK     = 32'h00ffffff;
  localparam logic [7:0]       ALPHA_LIMIT    = 8'h7f;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FILTER_MODE  = 2'd2,
    CFG_ALPHA_CUTOFF = 2'd3
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pixel_t;

  function automatic pixel_t half_bytes(input pixel_t v);
    half_bytes = (v & BYTE_LSB_CLEAR) >> 1;
  endfunction

  function automatic pixel_t pair_average(input pixel_t a, input pixel_t b);
    pair_average = half_bytes(half_bytes(a) + half_bytes(b));
  endfunction

endpackage

### sv/mipbox_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mipbox_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/mipmap_box_downsampler.sv
// mipmap_box_downsampler: 2x2 box / pick downsampler with a half-width line buffer
// depends on mipbox_pkg, mipbox_ram and assert_macros.svh
//
// usage:
//   source pixels arrive on the in_ stream in raster order, one beat per pixel.
//   one half-size pixel leaves on the out_ stream per 2x2 block, caused by the
//   lower-right source pixel; out_tlast marks the final pixel of the level.
//   an odd last column or row is consumed without output.
//   throughput is one pixel per cycle unless in_tready drops: each pixel does at
//   most one line buffer access (write on upper rows, read on lower rows).
//   a result goes from the lower-right input beat through the line buffer read
//   and the output register to out_tvalid; a stalled receiver fills the output
//   register, then one result stage; in_tready drops only while both are full.
//   reset clears counters, valids and config registers (width 2, height 2, box
//   mode, no alpha cutoff); the line buffer is not cleared and needs no sweep.
//   the user must write configuration through cfg_we/cfg_addr/cfg_wdata only
//   while idle; the block itself does not enforce this.
`include "assert_macros.svh"

module mipmap_box_downsampler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mipbox_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mipbox_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mipbox_pkg::PIX_W-1:0]       in_tdata,   // source_pixel[31:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mipbox_pkg::PIX_W-1:0]       out_tdata,  // dest_pixel[31:0]
  output logic                               out_tlast
);

  logic [mipbox_pkg::CFG_WID_W-1:0] width_r;
  logic [mipbox_pkg::CFG_HGT_W-1:0] height_r;
  logic                             mode_r;
  logic                             cutoff_r;

  logic [mipbox_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [mipbox_pkg::ROW_W-1:0]     row_r, row_nxt;
  mipbox_pkg::pixel_t               held_r;

  logic                             s1_valid_r, s1_valid_nxt;
  mipbox_pkg::pixel_t               s1_pair_r;
  logic                             s1_last_r;

  logic                             out_valid_r, out_valid_nxt;
  mipbox_pkg::pixel_t               out_data_r;
  logic                             out_last_r;

  logic [mipbox_pkg::EW_W-1:0]      ew, used_w, col_inc;
  logic [mipbox_pkg::EH_W-1:0]      eh, used_h, row_inc;
  logic                             accept, in_area, odd_col, odd_row;
  logic                             ram_we, ram_re, s1_move, is_last;
  logic [mipbox_pkg::SLOT_W-1:0]    slot;
  mipbox_pkg::pixel_t               pair, ram_rdata, res;

  // effective dimensions
  always_comb begin
    if (width_r == '0) begin
      ew = mipbox_pkg::EW_W'(1);
    end else if (width_r > mipbox_pkg::CFG_WID_W'(mipbox_pkg::MAX_WIDTH)) begin
      ew = mipbox_pkg::EW_W'(mipbox_pkg::MAX_WIDTH);
    end else begin
      ew = mipbox_pkg::EW_W'(width_r);
    end
    if (height_r == '0) begin
      eh = mipbox_pkg::EH_W'(1);
    end else if (height_r > mipbox_pkg::CFG_HGT_W'(mipbox_pkg::MAX_HEIGHT)) begin
      eh = mipbox_pkg::EH_W'(mipbox_pkg::MAX_HEIGHT);
    end else begin
      eh = mipbox_pkg::EH_W'(height_r);
    end
    used_w = {ew[mipbox_pkg::EW_W-1:1], 1'b0};
    used_h = {eh[mipbox_pkg::EH_W-1:1], 1'b0};
  end

  assign in_tready = !s1_valid_r || !out_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);

  assign odd_col = col_r[0];
  assign odd_row = row_r[0];
  assign in_area = (mipbox_pkg::EW_W'(col_r) < used_w) && (mipbox_pkg::EH_W'(row_r) < used_h);
  assign slot    = col_r[mipbox_pkg::COL_W-1:1];
  assign pair    = mode_r ? held_r : mipbox_pkg::pair_average(held_r, in_tdata);
  assign ram_we  = accept && in_area && odd_col && !odd_row;
  assign ram_re  = accept && in_area && odd_col && odd_row;
  assign is_last = (mipbox_pkg::EW_W'(col_r) == used_w - 1'b1)
                && (mipbox_pkg::EH_W'(row_r) == used_h - 1'b1);

  mipbox_ram #(
    .WIDTH (mipbox_pkg::PIX_W),
    .DEPTH (mipbox_pkg::LINE_DEPTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (pair),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // position advance
  always_comb begin
    col_inc = mipbox_pkg::EW_W'(col_r) + 1'b1;
    row_inc = mipbox_pkg::EH_W'(row_r) + 1'b1;
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= ew) begin
        col_nxt = '0;
        row_nxt = (row_inc >= eh) ? '0 : row_inc[mipbox_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_inc[mipbox_pkg::COL_W-1:0];
      end
    end
  end

  // combine upper row entry with lower row pair (pick mode: upper entry only), then apply alpha cutoff
  always_comb begin
    res = mode_r ? ram_rdata : ram_rdata + s1_pair_r;
    if (cutoff_r && (res[31:24] < mipbox_pkg::ALPHA_LIMIT)) begin
      res = res & mipbox_pkg::COLOR_MASK;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (ram_re) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= mipbox_pkg::CFG_WID_W'(2);
      height_r    <= mipbox_pkg::CFG_HGT_W'(2);
      mode_r      <= 1'b0;
      cutoff_r    <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      held_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (mipbox_pkg::cfg_idx_t'(cfg_addr))
          mipbox_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[mipbox_pkg::CFG_WID_W-1:0];
          mipbox_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[mipbox_pkg::CFG_HGT_W-1:0];
          mipbox_pkg::CFG_FILTER_MODE:  mode_r   <= cfg_wdata[0];
          mipbox_pkg::CFG_ALPHA_CUTOFF: cutoff_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && in_area && !odd_col) begin
        held_r <= in_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_pair_r <= pair;
      s1_last_r <= is_last;
    end
    if (s1_move) begin
      out_data_r <= res;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `ASSERT_NEVER(a_one_ram_access, ram_we && ram_re)
  `ASSERT_NEXT(a_read_fills_stage, ram_re, s1_valid_r)
  `ASSERT_IMPL(a_stage_from_read, s1_valid_r && !$past(s1_valid_r), $past(ram_re))
  `ASSERT_NEXT(a_stall_holds_stage, s1_valid_r && out_valid_r && !out_tready,
               s1_valid_r && out_valid_r)

endmodule

### tb/sv/tb_mipmap_box_downsampler.sv
// self-checking testbench of mipmap_box_downsampler: directed and random levels,
// every result checked against an in-bench prediction of the 2x2 downsample
// depends on mipbox_pkg and the mipmap_box_downsampler rtl
`timescale 1ns / 1ps

module tb_mipmap_box_downsampler;

  localparam logic MODE_BOX   = 1'b0;
  localparam logic MODE_PICK  = 1'b1;
  localparam int   IDLE_LIMIT = 2000;
  localparam int   SETTLE_CYC = 4;
  localparam int   TAIL_CYC   = 8;

  typedef logic [mipbox_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct {
    mipbox_pkg::pixel_t pixel;
    logic               last;
  } mip_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [mipbox_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  cfg_word_t                         cfg_wdata = '0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [mipbox_pkg::PIX_W-1:0]      in_tdata = '0;   // source_pixel[31:0]
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [mipbox_pkg::PIX_W-1:0]      out_tdata;       // dest_pixel[31:0]
  logic                              out_tlast;

  mip_result_t expected_pixels[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  int          send_idle = 0;
  int          recv_stall = 0;

  // predicted block state
  mipbox_pkg::pixel_t line_buf [mipbox_pkg::LINE_DEPTH];
  mipbox_pkg::pixel_t left_px = '0;
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;
  int unsigned        reg_width = 2;
  int unsigned        reg_height = 2;
  logic               reg_mode = MODE_BOX;
  logic               reg_cutoff = 1'b0;

  mipmap_box_downsampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin : check_beat
    mip_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual pixel %h last %b",
                 $time, out_tdata, out_tlast);
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata !== want.pixel) begin
          errors++;
          $display("%0t: dest_pixel mismatch, expected %h actual %h",
                   $time, want.pixel, out_tdata);
        end
        if (out_tlast !== want.last) begin
          errors++;
          $display("%0t: last_of_level mismatch, expected %b actual %b",
                   $time, want.last, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("mipmap_box_downsampler test failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic mipbox_pkg::pixel_t pair_mean(input mipbox_pkg::pixel_t a,
                                                   input mipbox_pkg::pixel_t b);
    mipbox_pkg::pixel_t m;
    for (int i = 0; i < 4; i++) begin
      m[8*i +: 8] = ((a[8*i +: 8] >> 1) + (b[8*i +: 8] >> 1)) >> 1;
    end
    return m;
  endfunction

  task automatic predict_mip_pixel(input mipbox_pkg::pixel_t px);
    int unsigned        ew, eh, uw, uh, slot;
    mipbox_pkg::pixel_t pair, res;
    mip_result_t        r;
    ew = clamp_dim(reg_width, mipbox_pkg::MAX_WIDTH);
    eh = clamp_dim(reg_height, mipbox_pkg::MAX_HEIGHT);
    uw = ew & ~32'd1;
    uh = eh & ~32'd1;
    if (col_pos < uw && row_pos < uh) begin
      if (col_pos % 2 == 0) begin
        left_px = px;
      end else begin
        slot = (col_pos >> 1) % mipbox_pkg::LINE_DEPTH;
        pair = (reg_mode == MODE_PICK) ? left_px : pair_mean(left_px, px);
        if (row_pos % 2 == 0) begin
          line_buf[slot] = pair;
        end else begin
          res = (reg_mode == MODE_PICK) ? line_buf[slot] : line_buf[slot] + pair;
          if (reg_cutoff && res[31:24] < mipbox_pkg::ALPHA_LIMIT) begin
            res = res & mipbox_pkg::COLOR_MASK;
          end
          r.pixel = res;
          r.last  = (col_pos == uw - 1 && row_pos == uh - 1);
          expected_pixels.push_back(r);
        end
      end
    end
    col_pos++;
    if (col_pos >= ew) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= eh) row_pos = 0;
    end
  endtask

  task automatic send_pixel(input mipbox_pkg::pixel_t px);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    predict_mip_pixel(px);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic settle_block();
    hold_until_drained();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input mipbox_pkg::cfg_idx_t idx, input cfg_word_t value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      mipbox_pkg::CFG_IMAGE_WIDTH:  reg_width  = 32'(value[mipbox_pkg::CFG_WID_W-1:0]);
      mipbox_pkg::CFG_IMAGE_HEIGHT: reg_height = 32'(value[mipbox_pkg::CFG_HGT_W-1:0]);
      mipbox_pkg::CFG_FILTER_MODE:  reg_mode   = value[0];
      mipbox_pkg::CFG_ALPHA_CUTOFF: reg_cutoff = value[0];
      default: ;
    endcase
  endtask

  task automatic program_level(input cfg_word_t w, input cfg_word_t h,
                               input cfg_word_t mode, input cfg_word_t cut);
    settle_block();
    write_reg(mipbox_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(mipbox_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(mipbox_pkg::CFG_FILTER_MODE, mode);
    write_reg(mipbox_pkg::CFG_ALPHA_CUTOFF, cut);
  endtask

  function automatic mipbox_pkg::pixel_t random_pixel();
    if ($urandom_range(99) < 20) return {8'($urandom_range(8'h7c, 8'h82)), 24'($urandom)};
    return $urandom;
  endfunction

  // sends one whole level; noisy levels add drain pauses and mode or cutoff flips
  task automatic send_level(input bit noisy);
    int unsigned count;
    count = clamp_dim(reg_width, mipbox_pkg::MAX_WIDTH)
          * clamp_dim(reg_height, mipbox_pkg::MAX_HEIGHT);
    for (int unsigned i = 0; i < count; i++) begin
      if (noisy && $urandom_range(99) < 2) begin
        hold_until_drained();
      end else if (noisy && $urandom_range(199) == 0) begin
        settle_block();
        if ($urandom_range(1)) begin
          write_reg(mipbox_pkg::CFG_FILTER_MODE, {12'($urandom), !reg_mode});
        end else begin
          write_reg(mipbox_pkg::CFG_ALPHA_CUTOFF, {12'($urandom), !reg_cutoff});
        end
      end
      send_pixel(random_pixel());
    end
  endtask

  task automatic test_pixel_extremes();
    program_level(13'd2, 13'd2, cfg_word_t'(MODE_BOX), 13'd0);
    send_pixel(32'h0);
    send_pixel(32'hffffffff);
    send_pixel(32'hffffffff);
    send_pixel(32'h0);
    repeat (4) send_pixel(32'hffffffff);
    program_level(13'd2, 13'd2, cfg_word_t'(MODE_PICK), 13'd0);
    send_pixel(32'hffffffff);
    repeat (3) send_pixel(32'h0);
  endtask

  task automatic test_alpha_cutoff();
    program_level(13'd4, 13'd2, cfg_word_t'(MODE_PICK), 13'd1);
    send_pixel({8'h7e, 24'($urandom)});
    send_pixel($urandom);
    send_pixel({8'h7f, 24'($urandom)});
    repeat (5) send_pixel($urandom);
  endtask

  task automatic test_degenerate_sizes();
    program_level(13'd0, 13'd3, cfg_word_t'(MODE_BOX), 13'd0);
    send_level(0);
    program_level(13'd1, 13'd2, cfg_word_t'(MODE_BOX), 13'd0);
    send_level(0);
    program_level(13'd3, 13'd0, cfg_word_t'(MODE_BOX), 13'd0);
    send_level(0);
    program_level(13'd2, 13'd1, cfg_word_t'(MODE_PICK), 13'd0);
    send_level(0);
  endtask

  // mode flips and a width shrink while a level is in progress
  task automatic test_midlevel_writes();
    program_level(13'd4, 13'd4, cfg_word_t'(MODE_BOX), 13'd0);
    repeat (6) send_pixel($urandom);
    settle_block();
    write_reg(mipbox_pkg::CFG_FILTER_MODE, cfg_word_t'(MODE_PICK));
    repeat (6) send_pixel($urandom);
    settle_block();
    write_reg(mipbox_pkg::CFG_FILTER_MODE, cfg_word_t'(MODE_BOX));
    repeat (2) send_pixel($urandom);
    settle_block();
    write_reg(mipbox_pkg::CFG_IMAGE_WIDTH, 13'd2);
    send_pixel($urandom);
  endtask

  // a long odd row and a tall odd column of blocks
  task automatic test_wide_and_tall();
    program_level(13'd63, 13'd3, cfg_word_t'(MODE_BOX), 13'd1);
    send_level(0);
    program_level(13'd3, 13'd33, cfg_word_t'(MODE_PICK), 13'd0);
    send_level(0);
  endtask

  task automatic test_random_levels(input int idle_pct, input int stall_pct, input int items);
    int unsigned sent, w, h, r;
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(99);
      w = (r < 6) ? $urandom_range(1) : $urandom_range(2, 12);
      h = (r >= 6 && r < 12) ? $urandom_range(1) : $urandom_range(2, 8);
      program_level({1'($urandom), 12'(w)}, 13'(h), {12'($urandom), 1'($urandom)},
                    {12'($urandom), 1'($urandom)});
      sent += clamp_dim(reg_width, mipbox_pkg::MAX_WIDTH)
            * clamp_dim(reg_height, mipbox_pkg::MAX_HEIGHT);
      send_level(1);
    end
    settle_block();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle  = 19;
    recv_stall = 19;
    test_pixel_extremes();
    test_alpha_cutoff();
    test_degenerate_sizes();
    test_midlevel_writes();
    test_wide_and_tall();
    test_random_levels(0, 0, 170);
    test_random_levels(75, 0, 170);
    test_random_levels(0, 75, 170);
    test_random_levels(19, 19, 170);
    hold_until_drained();
    repeat (TAIL_CYC) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("mipmap_box_downsampler test passed");
    end else begin
      $display("mipmap_box_downsampler test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/mipbox_pkg.sv
sv/mipbox_ram.sv
sv/mipmap_box_downsampler.sv
tb/sv/tb_mipmap_box_downsampler.sv
